// ----- rtl/vsd_pkg.sv -----
// vsd_pkg: types and constants shared by the varint stream decoder files
// no dependencies
`default_nettype none

package vsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 4;

  // bit 7 of each byte says another byte follows
  localparam int unsigned ContBit = 7;

  localparam logic [CountW-1:0] FullBytes = 4'd4;
  localparam logic [CountW-1:0] TopByte   = 4'd5;
  localparam logic [CountW-1:0] MaxBytes  = 4'd10;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_in_buffer;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] byte_count;
    logic              error;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/vsd_if.sv -----
// vsd_in_if / vsd_out_if: valid-ready channels for raw bytes and decoded values
// no dependencies
`default_nettype none

interface vsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_buffer;

  modport source(output valid, output data_byte, output last_in_buffer, input ready);
  modport sink(input valid, input data_byte, input last_in_buffer, output ready);
endinterface

interface vsd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [3:0]  byte_count;
  logic        error;

  modport source(output valid, output value, output byte_count, output error, input ready);
  modport sink(input valid, input value, input byte_count, input error, output ready);
endinterface

`default_nettype wire

// ----- rtl/vsd_in_reg.sv -----
// vsd_in_reg: input register stage holding one byte for the decode logic
// depends on vsd_pkg
`default_nettype none

module vsd_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vsd_pkg::item_t in_item,
  input  logic          advance,
  output logic          item_valid,
  output vsd_pkg::item_t item
);
  import vsd_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // the stage frees up whenever its byte moves on in the same cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ----- rtl/vsd_dec.sv -----
// vsd_dec: varint accumulator, byte counter and sticky error flag
// depends on vsd_pkg
`default_nettype none

module vsd_dec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  vsd_pkg::item_t   item,
  output logic             emit,
  output vsd_pkg::result_t res
);
  import vsd_pkg::*;

  logic [ValueW-1:0] acc_r, acc_nxt;
  logic [CountW-1:0] seen_r, seen_nxt;
  logic              err_r, err_nxt;

  logic [ValueW-1:0] payload;
  logic [ValueW-1:0] acc_sum;
  logic [CountW-1:0] n;
  logic              cont;
  logic              hold;

  assign n    = seen_r + 4'd1;
  assign cont = item.data_byte[ContBit];

  // place the payload bits by byte position; past byte five nothing is kept
  always_comb begin
    payload = '0;
    unique case (seen_r)
      4'd0:    payload = {25'd0, item.data_byte[6:0]};
      4'd1:    payload = {18'd0, item.data_byte[6:0], 7'd0};
      4'd2:    payload = {11'd0, item.data_byte[6:0], 14'd0};
      4'd3:    payload = {4'd0, item.data_byte[6:0], 21'd0};
      4'd4:    payload = {item.data_byte[3:0], 28'd0};
      default: payload = '0;
    endcase
  end

  assign acc_sum = acc_r | payload;
  assign hold    = cont && (n < MaxBytes) && !item.last_in_buffer;
  assign emit    = fire && !err_r && !hold;

  always_comb begin
    acc_nxt  = acc_r;
    seen_nxt = seen_r;
    err_nxt  = err_r;
    if (fire && !err_r) begin
      if (hold) begin
        acc_nxt  = acc_sum;
        seen_nxt = n;
      end else begin
        acc_nxt  = '0;
        seen_nxt = '0;
        err_nxt  = cont;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      seen_r <= '0;
      err_r  <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      seen_r <= seen_nxt;
      err_r  <= err_nxt;
    end
  end

  assign res.value      = acc_sum;
  assign res.byte_count = n;
  assign res.error      = cont;

endmodule

`default_nettype wire

// ----- rtl/vsd_out_reg.sv -----
// vsd_out_reg: result register on the output channel
// depends on vsd_pkg
`default_nettype none

module vsd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  vsd_pkg::result_t res_in,
  input  logic             out_ready,
  output logic             out_valid,
  output vsd_pkg::result_t res_out,
  output logic             can_load
);
  import vsd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

// ----- rtl/varint_stream_decoder.sv -----
// varint_stream_decoder: base-128 varint bytes in, 32-bit values out
// depends on vsd_pkg, vsd_if, vsd_in_reg, vsd_dec, vsd_out_reg
//
//   channel   dir   payload                          transaction
//   in_ch     in    data_byte[8], last_in_buffer     one raw byte
//   out_ch    out   value[32], byte_count[4], error  one decoded varint
//
// one byte per cycle sustained while out_ch accepts; after its final byte is taken,
// a result passes through the input register and then the result register
// the decode step between them is a shift-or into the accumulator
// synchronous active-low reset clears the accumulator, byte count and error flag
// a stalled out_ch holds the result register, which in turn holds the input stage
`default_nettype none

module varint_stream_decoder (
  input  logic      clk,
  input  logic      rst_n,
  vsd_in_if.sink    in_ch,
  vsd_out_if.source out_ch
);
  import vsd_pkg::*;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    advance;
  logic    emit;
  result_t dec_res;
  result_t out_res;

  assign in_item.data_byte      = in_ch.data_byte;
  assign in_item.last_in_buffer = in_ch.last_in_buffer;

  vsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (stage_valid),
    .item       (stage_item)
  );

  logic can_load;

  assign advance = stage_valid && can_load;

  vsd_dec u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (stage_item),
    .emit  (emit),
    .res   (dec_res)
  );

  vsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .res_in    (dec_res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .res_out   (out_res),
    .can_load  (can_load)
  );

  assign out_ch.value      = out_res.value;
  assign out_ch.byte_count = out_res.byte_count;
  assign out_ch.error      = out_res.error;

endmodule

`default_nettype wire

// ----- tb/sv/varint_stream_decoder_tb.sv -----
// varint_stream_decoder_tb: self-checking bench for the base-128 varint byte decoder
// checks every decoded varint against a behavioral decoder kept in the bench
// depends on vsd_pkg, vsd_if and the varint_stream_decoder rtl
`timescale 1ns / 1ps

module varint_stream_decoder_tb;
  import vsd_pkg::*;

  localparam int HoldCycles = 300;

  logic clk;
  logic rst_n;

  vsd_in_if  in_ch ();
  vsd_out_if out_ch ();

  varint_stream_decoder DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // behavioral decoder state
  logic [ValueW-1:0] dec_acc;
  logic [CountW-1:0] dec_count;
  logic              dec_dead;
  result_t           expected_varints[$];

  bit src_idle_on;
  bit sink_stall_on;
  int hold_seq;
  int hold_done;

  int mismatches;
  int bytes_sent;
  int varints_checked;
  int in_stall_cycles;
  int error_kind;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // shift-or decode of one accepted byte
  task automatic decode_byte(input logic [ByteW-1:0] b, input logic is_last);
    logic [CountW-1:0] pos;
    logic              more;
    result_t           r;
    if (dec_dead) return;
    pos = dec_count + 4'd1;
    if (pos <= FullBytes) begin
      dec_acc = dec_acc | ({25'd0, b[6:0]} << (7 * (pos - 1)));
    end else if (pos == TopByte) begin
      dec_acc = dec_acc | {b[3:0], 28'd0};
    end
    more = b[ContBit];
    if (more && pos < MaxBytes && !is_last) begin
      dec_count = pos;
      return;
    end
    r.value      = dec_acc;
    r.byte_count = pos;
    r.error      = more;
    expected_varints.push_back(r);
    dec_acc   = '0;
    dec_count = '0;
    if (more) dec_dead = 1'b1;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic is_last);
    while (src_idle_on && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.last_in_buffer <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    decode_byte(b, is_last);
  endtask

  // well-formed varint with random payload; last_in_buffer only on the closing byte
  task automatic send_varint(input int len, input bit allow_last);
    logic [ByteW-1:0] b;
    logic             is_last;
    for (int k = 1; k <= len; k++) begin
      b = 8'($urandom_range(255));
      case ($urandom_range(9))
        0: b[6:0] = '0;
        1: b[6:0] = '1;
        default: ;
      endcase
      b[ContBit] = (k < len);
      is_last = (k == len) && allow_last && ($urandom_range(7) == 0);
      send_byte(b, is_last);
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 35) return 1;
    if (r < 55) return 2;
    if (r < 70) return 3;
    if (r < 80) return 4;
    if (r < 90) return 5;
    return $urandom_range(6, 10);
  endfunction

  task automatic test_directed_values();
    send_byte(8'h00, 1'b0);
    // closing byte marked last is still a clean result
    send_byte(8'h7f, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    // full 32-bit value
    repeat (4) send_byte(8'hff, 1'b0);
    send_byte(8'h0f, 1'b0);
    // bits 4 to 6 of byte five are dropped
    repeat (4) send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    // ten-byte varint, bytes six to ten ignored
    repeat (9) send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_stream(input int n_bytes, input bit idle);
    int start;
    src_idle_on   = idle;
    sink_stall_on = idle;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_varint(pick_len(), 1'b1);
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    hold_seq++;
    repeat (60) send_varint($urandom_range(1, 2), 1'b0);
    src_idle_on = 1'b1;
  endtask

  // an error is sticky until reset, so this has to be the last test
  task automatic test_error_then_dropped();
    int len;
    error_kind = $urandom_range(1);
    if (error_kind == 0) begin
      for (int k = 0; k < 10; k++) send_byte(8'($urandom_range(255)) | 8'h80, 1'b0);
    end else begin
      len = $urandom_range(1, 9);
      for (int k = 1; k <= len; k++) begin
        send_byte(8'($urandom_range(255)) | 8'h80, k == len);
      end
    end
    // all of these must be swallowed
    repeat (30) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // sink side: random stalls plus one long hold-off on request
  initial begin : sink_side
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_done) begin
        hold_done = hold_seq;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
      end else begin
        out_ch.ready <= !(sink_stall_on && $urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && !in_ch.ready) in_stall_cycles++;
  end

  // compare each decoded varint with the oldest prediction
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_varints.size() == 0) begin
        $error("unexpected result transaction: value %h count %0d error %0b",
               out_ch.value, out_ch.byte_count, out_ch.error);
        mismatches++;
      end else begin
        exp_r = expected_varints.pop_front();
        varints_checked++;
        if (out_ch.value !== exp_r.value) begin
          $error("value: expected %h, got %h", exp_r.value, out_ch.value);
          mismatches++;
        end
        if (out_ch.byte_count !== exp_r.byte_count) begin
          $error("byte_count: expected %0d, got %0d", exp_r.byte_count, out_ch.byte_count);
          mismatches++;
        end
        if (out_ch.error !== exp_r.error) begin
          $error("error: expected %0b, got %0b", exp_r.error, out_ch.error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.last_in_buffer = 1'b0;
    rst_n         = 1'b0;
    dec_acc       = '0;
    dec_count     = '0;
    dec_dead      = 1'b0;
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    hold_seq      = 0;
    hold_done     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_values();
    test_random_stream(300, 1'b0);
    test_output_backpressure();
    test_random_stream(850, 1'b1);
    test_error_then_dropped();

    in_ch.valid <= 1'b0;
    for (int i = 0; i < 2000 && expected_varints.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_varints.size() != 0) begin
      $error("%0d expected varints never arrived", expected_varints.size());
      mismatches++;
    end

    $display("sent %0d bytes, checked %0d decoded varints, input stalled %0d cycles",
             bytes_sent, varints_checked, in_stall_cycles);
    $display("stream ended on %s, followed by bytes that had to be dropped",
             error_kind == 0 ? "an overlong varint" : "a buffer cut mid-varint");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
